FILE: src/frqs_pkg.sv
// shared types and constants of the fifo run queue scheduler
package frqs_pkg;

    localparam int OP_W    = 2;
    localparam int ID_W    = 8;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

    // read address select for the queue memory
    typedef enum logic [1:0] {
        RA_IDX   = 2'd0,
        RA_IDX1  = 2'd1,
        RA_IDX2  = 2'd2,
        RA_ZERO  = 2'd3
    } rd_sel_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic    capture;
        rd_sel_t rd_sel;
        logic    idx_inc;
        logic    wr_tail;
        logic    wr_shift;
        logic    cnt_dec;
        logic    set_ovf;
        logic    set_pick;
        logic    load_out;
    } cmd_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            stopped;
        logic            cnt_zero;
        logic            cnt_one;
        logic            cnt_full;
        logic            next1_ok;
        logic            next2_ok;
        logic            match;
    } stat_t;

endpackage

FILE: src/frqs_ctrl.sv
// sequencer of the fifo run queue scheduler
module frqs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  frqs_pkg::stat_t  stat,
    output frqs_pkg::cmd_t   cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EXEC   = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_SHIFT  = 7'b0001000,
        ST_FETCH  = 7'b0010000,
        ST_HEAD   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_sel   = frqs_pkg::RA_IDX;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (stat.op)
                    frqs_pkg::OP_ADD: begin
                        if (stat.cnt_full) begin
                            cmd.set_ovf = 1'b1;
                        end else begin
                            cmd.wr_tail = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    frqs_pkg::OP_REMOVE: begin
                        cmd.rd_sel = frqs_pkg::RA_IDX;
                        state_next = stat.cnt_zero ? ST_DONE : ST_SEARCH;
                    end
                    frqs_pkg::OP_PICK: begin
                        if (stat.cnt_zero) begin
                            state_next = ST_DONE;
                        end else if (stat.cnt_one || !stat.stopped) begin
                            cmd.rd_sel = frqs_pkg::RA_ZERO;
                            state_next = ST_HEAD;
                        end else begin
                            cmd.rd_sel = frqs_pkg::RA_IDX1;
                            state_next = ST_SHIFT;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SEARCH: begin
                if (stat.match) begin
                    if (stat.next1_ok) begin
                        cmd.rd_sel = frqs_pkg::RA_IDX1;
                        state_next = ST_SHIFT;
                    end else begin
                        cmd.cnt_dec = 1'b1;
                        state_next  = ST_DONE;
                    end
                end else if (stat.next1_ok) begin
                    cmd.rd_sel  = frqs_pkg::RA_IDX1;
                    cmd.idx_inc = 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                cmd.wr_shift = 1'b1;
                if (stat.next2_ok) begin
                    cmd.rd_sel  = frqs_pkg::RA_IDX2;
                    cmd.idx_inc = 1'b1;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = (stat.op == frqs_pkg::OP_PICK) ? ST_FETCH : ST_DONE;
                end
            end
            ST_FETCH: begin
                cmd.rd_sel = frqs_pkg::RA_ZERO;
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                cmd.set_pick = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: src/frqs_dp.sv
// queue memory, count, scan index and result registers
module frqs_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [frqs_pkg::OP_W-1:0]     s_operation,
    input  logic [frqs_pkg::ID_W-1:0]     s_entity_id,
    input  logic                          s_head_stopped,
    input  frqs_pkg::cmd_t                cmd,
    output frqs_pkg::stat_t               stat,
    output logic                          m_pick_valid,
    output logic [frqs_pkg::ID_W-1:0]     m_picked_id,
    output logic [frqs_pkg::COUNT_W-1:0]  m_queue_count,
    output logic                          m_overflow
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = CW + 1;
    localparam int QW = CW + frqs_pkg::COUNT_W;

    logic [frqs_pkg::ID_W-1:0] mem [QUEUE_DEPTH];

    logic [frqs_pkg::OP_W-1:0] op_reg;
    logic [frqs_pkg::ID_W-1:0] id_reg;
    logic                      stopped_reg;
    logic [CW-1:0]             count_reg;
    logic [AW-1:0]             idx_reg;
    logic [frqs_pkg::ID_W-1:0] rd_data_reg;
    logic                      res_valid_reg;
    logic [frqs_pkg::ID_W-1:0] res_id_reg;
    logic                      res_ovf_reg;
    logic                      out_valid_reg;
    logic [frqs_pkg::ID_W-1:0] out_id_reg;
    logic [frqs_pkg::COUNT_W-1:0] out_count_reg;
    logic                      out_ovf_reg;

    logic [XW-1:0]             idx_x;
    logic [XW-1:0]             cnt_x;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             wr_addr;
    logic [frqs_pkg::ID_W-1:0] wr_data;
    logic                      wr_en;
    logic [QW-1:0]             count_wide;

    assign idx_x = XW'(idx_reg);
    assign cnt_x = XW'(count_reg);

    always_comb begin
        case (cmd.rd_sel)
            frqs_pkg::RA_IDX:  rd_addr = idx_reg;
            frqs_pkg::RA_IDX1: rd_addr = AW'(idx_x + XW'(1));
            frqs_pkg::RA_IDX2: rd_addr = AW'(idx_x + XW'(2));
            frqs_pkg::RA_ZERO: rd_addr = '0;
            default:           rd_addr = idx_reg;
        endcase
    end

    // tail append for add, one-step gap closing for remove and pick
    assign wr_en   = cmd.wr_tail || cmd.wr_shift;
    assign wr_addr = cmd.wr_tail ? AW'(count_reg) : idx_reg;
    assign wr_data = cmd.wr_tail ? id_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        stat          = '0;
        stat.op       = op_reg;
        stat.stopped  = stopped_reg;
        stat.cnt_zero = (count_reg == '0);
        stat.cnt_one  = (count_reg == CW'(1));
        stat.cnt_full = (count_reg == CW'(QUEUE_DEPTH));
        stat.next1_ok = ((idx_x + XW'(1)) < cnt_x);
        stat.next2_ok = ((idx_x + XW'(2)) < cnt_x);
        stat.match    = (rd_data_reg == id_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.wr_tail) begin
            count_reg <= count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg        <= s_operation;
            id_reg        <= s_entity_id;
            stopped_reg   <= s_head_stopped;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_id_reg    <= '0;
            res_ovf_reg   <= 1'b0;
        end else begin
            if (cmd.idx_inc) begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (cmd.set_ovf) begin
                res_ovf_reg <= 1'b1;
            end
            if (cmd.set_pick) begin
                res_valid_reg <= 1'b1;
                res_id_reg    <= rd_data_reg;
            end
        end
    end

    assign count_wide = QW'(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_valid_reg <= res_valid_reg;
            out_id_reg    <= res_id_reg;
            out_count_reg <= count_wide[frqs_pkg::COUNT_W-1:0];
            out_ovf_reg   <= res_ovf_reg;
        end
    end

    assign m_pick_valid  = out_valid_reg;
    assign m_picked_id   = out_id_reg;
    assign m_queue_count = out_count_reg;
    assign m_overflow    = out_ovf_reg;

endmodule

FILE: src/fifo_run_queue_scheduler_core.sv
// top level of the fifo run queue scheduler
//
// usage
//   input channel s_*: one word per operation (add, remove or pick) with the
//   task identifier and, for pick, the head-stopped flag
//   result channel m_*: exactly one word per input word, in order, carrying
//   the pick result, the queue count after the operation and the overflow flag
// throughput
//   one word at a time; the queue memory has one write and one registered read
//   port, so remove scans one entry per cycle and closes the gap one entry per
//   cycle; an add passes the exec and done states, a plain pick exec, head and
//   done, and a pick that drops a stopped head also shifts and fetches the head;
//   the result word and s_ready return in the same cycle
// reset
//   aresetn clears the count and the sequencer; the queue memory is not
//   cleared, entries at or beyond the count are never read
// stall
//   the result word sits in the output register until m_ready; the next input
//   word is taken meanwhile and runs up to the point where its result is due
module fifo_run_queue_scheduler_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [frqs_pkg::OP_W-1:0]     s_operation,
    input  logic [frqs_pkg::ID_W-1:0]     s_entity_id,
    input  logic                          s_head_stopped,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_pick_valid,
    output logic [frqs_pkg::ID_W-1:0]     m_picked_id,
    output logic [frqs_pkg::COUNT_W-1:0]  m_queue_count,
    output logic                          m_overflow
);

    // command and status between sequencer and datapath
    frqs_pkg::cmd_t  cmd;
    frqs_pkg::stat_t stat;

    // sequencer: decode, scan, shift, head fetch and result handoff
    frqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: queue memory, count, scan index and output word register
    frqs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_operation    (s_operation),
        .s_entity_id    (s_entity_id),
        .s_head_stopped (s_head_stopped),
        .cmd            (cmd),
        .stat           (stat),
        .m_pick_valid   (m_pick_valid),
        .m_picked_id    (m_picked_id),
        .m_queue_count  (m_queue_count),
        .m_overflow     (m_overflow)
    );

endmodule

FILE: src/frqs_checker.sv
// port-level checks of the fifo run queue scheduler and their bind
module frqs_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_pick_valid,
    input  logic [frqs_pkg::ID_W-1:0]     m_picked_id,
    input  logic [frqs_pkg::COUNT_W-1:0]  m_queue_count,
    input  logic                          m_overflow
);

    localparam logic [frqs_pkg::COUNT_W-1:0] FULL_COUNT =
        frqs_pkg::COUNT_W'(QUEUE_DEPTH);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pick_valid)
            && $stable(m_picked_id) && $stable(m_queue_count) && $stable(m_overflow))
        else $error("result word changed while stalled");

    // the block is busy the cycle after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on two consecutive cycles");

    // an overflow only happens on a full queue and never comes with a pick
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_queue_count == FULL_COUNT && !m_pick_valid)
        else $error("overflow with a queue that is not full");

    // no pick result means a zero identifier
    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pick_valid |-> m_picked_id == '0)
        else $error("identifier without a pick");

    // a pick result needs a non-empty queue
    a_pick_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pick_valid && QUEUE_DEPTH < 32 |-> m_queue_count != '0)
        else $error("pick from an empty queue");

endmodule

bind fifo_run_queue_scheduler_core frqs_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_frqs_checker (.*);

FILE: tb/tb_fifo_run_queue_scheduler_core.sv
// self-checking testbench for the fifo run queue scheduler core
module tb_fifo_run_queue_scheduler_core;
    import frqs_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    // unused operation code, must leave the queue alone
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam int RANDOM_WORDS  = 1800;
    // no idling once this few words are left to send
    localparam int CALM_TAIL     = 150;
    // the long receiver hold starts once this many words went in
    localparam int PRESSURE_AT   = 500;
    localparam int PRESSURE_HOLD = 400;
    // slowest item is a full-depth remove or stopped pick
    localparam int DRAIN_CYCLES  = 2 * QUEUE_DEPTH + 12;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int REPORT_MAX    = 10;

    // one input word as the sender holds it
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic            stopped;
    } sched_word_t;

    // one result word, field for field as on the m_ ports
    typedef struct packed {
        logic               pick_valid;
        logic [ID_W-1:0]    picked_id;
        logic [COUNT_W-1:0] queue_count;
        logic               overflow;
    } sched_result_t;

    // stimulus shaping: push the queue toward full, toward empty, or neither
    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } load_mode_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [OP_W-1:0]    s_operation    = '0;
    logic [ID_W-1:0]    s_entity_id    = '0;
    logic               s_head_stopped = 1'b0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic               m_pick_valid;
    logic [ID_W-1:0]    m_picked_id;
    logic [COUNT_W-1:0] m_queue_count;
    logic               m_overflow;

    sched_word_t   pending_words[$];   // words still to be sent, head is on the bus
    sched_result_t due_results[$];     // predicted results in arrival order
    logic [ID_W-1:0] run_queue[$];     // predicted queue contents, index 0 is head

    int fail_count = 0;
    int words_in   = 0;
    int send_gap   = 0;
    int ready_gap  = 0;
    int hold_left  = 0;
    bit pressure_done = 1'b0;
    int idle_cycles = 0;

    always #10 aclk = ~aclk;

    fifo_run_queue_scheduler_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_entity_id   (s_entity_id),
        .s_head_stopped(s_head_stopped),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pick_valid  (m_pick_valid),
        .m_picked_id   (m_picked_id),
        .m_queue_count (m_queue_count),
        .m_overflow    (m_overflow)
    );

    // predicted effect of one word on the run queue and the result it gives
    function automatic sched_result_t run_queue_step(input sched_word_t w);
        sched_result_t r;
        r = '0;
        case (w.op)
            OP_ADD: begin
                // full queue drops the add and flags it, not sticky
                if (run_queue.size() < QUEUE_DEPTH) begin
                    run_queue.push_back(w.id);
                end else begin
                    r.overflow = 1'b1;
                end
            end
            OP_REMOVE: begin
                // only the match nearest the head goes, absent id is a no-op
                for (int i = 0; i < run_queue.size(); i++) begin
                    if (run_queue[i] == w.id) begin
                        run_queue.delete(i);
                        break;
                    end
                end
            end
            OP_PICK: begin
                // a lone entry is named whatever head_stopped says
                if (run_queue.size() >= 2 && w.stopped) begin
                    run_queue.delete(0);
                end
                if (run_queue.size() != 0) begin
                    r.pick_valid = 1'b1;
                    r.picked_id  = run_queue[0];
                end
            end
            default: begin
                // unused code: nothing changes
            end
        endcase
        r.queue_count = COUNT_W'(run_queue.size());
        return r;
    endfunction

    function automatic bit in_calm_tail();
        return pending_words.size() < CALM_TAIL;
    endfunction

    function automatic void push_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                      input logic stopped);
        sched_word_t w;
        w.op      = op;
        w.id      = id;
        w.stopped = stopped;
        pending_words.push_back(w);
    endfunction

    task automatic check_result(input sched_result_t want, input sched_result_t got);
        bit bad;
        bad = (got.pick_valid  !== want.pick_valid)  ||
              (got.picked_id   !== want.picked_id)   ||
              (got.queue_count !== want.queue_count) ||
              (got.overflow    !== want.overflow);
        if (bad) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
                $display("mismatch: pick_valid %0d/%0d picked_id %0h/%0h count %0d/%0d ovf %0d/%0d",
                         want.pick_valid, got.pick_valid, want.picked_id, got.picked_id,
                         want.queue_count, got.queue_count, want.overflow, got.overflow);
            end
        end
    endtask

    // sender: the head of pending_words stays on the bus until it is taken
    always @(posedge aclk) begin : sender
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!(s_valid && !s_ready)) begin
            // word just taken, drop it from the pending list
            if (s_valid) begin
                pending_words.delete(0);
            end
            if (send_gap != 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_words.size() != 0 && !in_calm_tail() &&
                         $urandom_range(0, 7) == 0) begin
                // start an idle burst
                s_valid  <= 1'b0;
                send_gap <= $urandom_range(0, 17);
            end else if (pending_words.size() != 0) begin
                s_valid        <= 1'b1;
                s_operation    <= pending_words[0].op;
                s_entity_id    <= pending_words[0].id;
                s_head_stopped <= pending_words[0].stopped;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts plus one long hold so the input backs up
    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!pressure_done && words_in >= PRESSURE_AT) begin
            m_ready       <= 1'b0;
            hold_left     <= PRESSURE_HOLD - 1;
            pressure_done <= 1'b1;
        end else if (ready_gap != 0) begin
            m_ready   <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else if (!in_calm_tail() && $urandom_range(0, 7) == 0) begin
            m_ready   <= 1'b0;
            ready_gap <= $urandom_range(0, 17);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predict on every accepted input word, check every accepted result
    always @(posedge aclk) begin : monitor
        sched_word_t   w;
        sched_result_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                w.op      = s_operation;
                w.id      = s_entity_id;
                w.stopped = s_head_stopped;
                due_results.push_back(run_queue_step(w));
                words_in++;
            end
            if (m_valid && m_ready) begin
                got.pick_valid  = m_pick_valid;
                got.picked_id   = m_picked_id;
                got.queue_count = m_queue_count;
                got.overflow    = m_overflow;
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("result word with nothing expected: count %0d", got.queue_count);
                    end
                end else begin
                    check_result(due_results.pop_front(), got);
                end
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("timeout: no word moved for %0d cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : main
        int              rand_words;
        int              span;
        int              roll;
        int              add_lim;
        int              rem_lim;
        load_mode_t      mode;
        logic [ID_W-1:0] id_pool[0:5];
        logic [ID_W-1:0] id;
        logic [OP_W-1:0] op;
        logic            stp;

        // directed part: empty queue first
        push_word(OP_PICK, 8'h00, 1'b1);
        push_word(OP_PICK, 8'h00, 1'b0);
        push_word(OP_REMOVE, 8'h5a, 1'b0);
        push_word(OP_NONE, 8'hff, 1'b1);
        // single entry, head_stopped must be ignored
        push_word(OP_ADD, 8'hff, 1'b0);
        push_word(OP_PICK, 8'h00, 1'b1);
        // duplicates: only the one nearest the head is removed
        push_word(OP_ADD, 8'h00, 1'b1);
        push_word(OP_ADD, 8'hff, 1'b0);
        push_word(OP_PICK, 8'h00, 1'b0);
        push_word(OP_REMOVE, 8'hff, 1'b1);
        push_word(OP_REMOVE, 8'h33, 1'b0);
        // two entries and a stopped head: head dropped, new head named
        push_word(OP_PICK, 8'hff, 1'b1);
        // fill to the brim, then one add too many and an unused code when full
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            push_word(OP_ADD, ID_W'(i * 17), i[0]);
        end
        push_word(OP_ADD, 8'haa, 1'b0);
        push_word(OP_NONE, 8'h00, 1'b0);
        // remove an id that sits at both ends: the copy at the head goes
        push_word(OP_REMOVE, ID_W'((QUEUE_DEPTH - 1) * 17), 1'b0);

        // random part in phases; a small id pool per phase makes removes hit
        rand_words = 0;
        while (rand_words < RANDOM_WORDS) begin
            mode = load_mode_t'($urandom_range(0, 2));
            span = $urandom_range(20, 120);
            foreach (id_pool[k]) begin
                id_pool[k] = ID_W'($urandom_range(0, 255));
            end
            case (mode)
                MODE_FILL:  begin add_lim = 70; rem_lim = 80; end
                MODE_DRAIN: begin add_lim = 15; rem_lim = 50; end
                default:    begin add_lim = 40; rem_lim = 65; end
            endcase
            for (int k = 0; k < span && rand_words < RANDOM_WORDS; k++) begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 3) == 0) begin
                    id = ID_W'($urandom_range(0, 255));
                end else begin
                    id = id_pool[$urandom_range(0, 5)];
                end
                stp = 1'($urandom_range(0, 1));
                if (roll < add_lim) begin
                    op = OP_ADD;
                end else if (roll < rem_lim) begin
                    op = OP_REMOVE;
                end else if (roll < 97) begin
                    op = OP_PICK;
                    // draining leans on stopped heads
                    if (mode == MODE_DRAIN) begin
                        stp = ($urandom_range(0, 3) != 0);
                    end
                end else begin
                    op = OP_NONE;
                end
                push_word(op, id, stp);
                rand_words++;
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || due_results.size() != 0) begin
            @(posedge aclk);
        end
        // let a stray extra word show up before closing
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (due_results.size() != 0) begin
            fail_count += due_results.size();
            $display("%0d expected result words never arrived", due_results.size());
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/frqs_pkg.sv
src/frqs_ctrl.sv
src/frqs_dp.sv
src/fifo_run_queue_scheduler_core.sv
src/frqs_checker.sv
tb/tb_fifo_run_queue_scheduler_core.sv
